/* rtl/pvif_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvif_pkg - shared types and constants for the phase vocoder frequency core
// Field widths, the CORDIC angle table, register indexes and stage types.
// ----------------------------------------------------------------------------
package pvif_pkg;

  localparam int MaxBins     = 1024;
  localparam int BinW        = $clog2(MaxBins);
  localparam int PhaseW      = 16;
  localparam int SampleW     = 24;
  localparam int FreqW       = 18;
  localparam int HopW        = 11;
  localparam int Log2W       = 4;
  localparam int CfgDataW    = 11;
  localparam int CordicSteps = 28;
  localparam int CordicW     = 34;  // |x|,|y| stay below 2^31 after gain
  localparam int DivSteps    = 16;  // magnitude of the scaled deviation fits 16 bits
  localparam int DivW        = 16;

  // Register indexes on the configuration port
  localparam logic REG_HOP   = 1'b0;
  localparam logic REG_LOG2N = 1'b1;

  // atan(2^-i) in units of 2*pi/2^32
  localparam logic [31:0] ATAN_TAB [CordicSteps] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5
  };

  // Data held by one CORDIC cell
  typedef struct packed {
    logic                      valid;
    logic [BinW-1:0]           j;
    logic                      first;
    logic                      zero;
    logic signed [CordicW-1:0] x;
    logic signed [CordicW-1:0] y;
    logic [31:0]               z;
  } cordic_t;

  // Data held by one divider cell
  typedef struct packed {
    logic            valid;
    logic [BinW-1:0] j;
    logic            neg;
    logic [HopW-1:0] rem;
    logic [DivW-1:0] n;
    logic [DivW-1:0] q;
  } div_t;

endpackage

/* rtl/pvif_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvif_if - stream interfaces of the phase vocoder frequency core
// Bin input stream and frequency output stream, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pvif_bin_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [pvif_pkg::SampleW-1:0]      bin_real;
  logic signed [pvif_pkg::SampleW-1:0]      bin_imag;
  logic [pvif_pkg::BinW-1:0]                bin_index;
  logic                                     first_frame;

  modport source (output valid, bin_real, bin_imag, bin_index, first_frame,
                  input ready);
  modport sink   (input valid, bin_real, bin_imag, bin_index, first_frame,
                  output ready);
endinterface

interface pvif_freq_if;
  logic                                valid;
  logic                                ready;
  logic signed [pvif_pkg::FreqW-1:0]   freq_angle;
  logic [pvif_pkg::BinW-1:0]           bin_index_out;

  modport source (output valid, freq_angle, bin_index_out, input ready);
  modport sink   (input valid, freq_angle, bin_index_out, output ready);
endinterface

/* rtl/pvif_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvif_cordic_cell - one vectoring step of the phase CORDIC
// Rotates towards the x axis by atan(2^-shift) and accumulates the angle.
// ----------------------------------------------------------------------------
module pvif_cordic_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  pvif_pkg::cordic_t   din,
  input  logic [4:0]          shift,
  input  logic [31:0]         angle,
  output pvif_pkg::cordic_t   dout
);

  logic signed [pvif_pkg::CordicW-1:0] xs;
  logic signed [pvif_pkg::CordicW-1:0] ys;
  pvif_pkg::cordic_t                   dout_next;

  assign xs = din.x >>> shift;
  assign ys = din.y >>> shift;

  // Rotate direction follows the sign of y
  always_comb begin
    dout_next = din;
    if (!din.y[pvif_pkg::CordicW-1]) begin
      dout_next.x = din.x + ys;
      dout_next.y = din.y - xs;
      dout_next.z = din.z + angle;
    end else begin
      dout_next.x = din.x - ys;
      dout_next.y = din.y + xs;
      dout_next.z = din.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

/* rtl/pvif_div_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvif_div_cell - one restoring division step
// Brings down one dividend bit, subtracts the hop size where it fits.
// ----------------------------------------------------------------------------
module pvif_div_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic [pvif_pkg::HopW-1:0]   hop,
  input  pvif_pkg::div_t              din,
  output pvif_pkg::div_t              dout
);

  logic [pvif_pkg::HopW:0] trial;
  logic [pvif_pkg::HopW:0] diff;
  logic                    fits;
  pvif_pkg::div_t          dout_next;

  assign trial = {din.rem, din.n[pvif_pkg::DivW-1]};
  assign diff  = trial - {1'b0, hop};
  assign fits  = (trial >= {1'b0, hop});

  always_comb begin
    dout_next     = din;
    dout_next.rem = fits ? diff[pvif_pkg::HopW-1:0] : trial[pvif_pkg::HopW-1:0];
    dout_next.n   = {din.n[pvif_pkg::DivW-2:0], 1'b0};
    dout_next.q   = {din.q[pvif_pkg::DivW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

/* rtl/phase_vocoder_inst_freq_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_vocoder_inst_freq_core - instantaneous frequency per DFT bin
// CORDIC phase, per-bin phase store, wrapped deviation and division by hop.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | handshake
//  bin     | in  | bin_real, bin_imag, bin_index, first_frame      | valid/ready
//  freq    | out | freq_angle, bin_index_out                       | valid/ready
//  cfg     | in  | cfg_index, cfg_data                             | cfg_we
//
//  One transaction per cycle while results are taken; the pipeline is the 28
//  CORDIC cells and the 16 divider cells plus five register stages.
//  First-frame transactions only update the phase store and give no result.
//  The whole pipeline advances together; it halts while the output register
//  holds a result that is not taken. Reset clears all valid flags and sets
//  the registers to hop 256 and log2 size 10; the phase store is not cleared.
// ----------------------------------------------------------------------------
module phase_vocoder_inst_freq_core (
  input  logic                           clk,
  input  logic                           rst,
  pvif_bin_if.sink                       bin,
  pvif_freq_if.source                    freq,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [pvif_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int BinW  = pvif_pkg::BinW;
  localparam int HopW  = pvif_pkg::HopW;
  localparam int Log2W = pvif_pkg::Log2W;
  localparam int PW    = pvif_pkg::PhaseW;
  localparam int DW    = pvif_pkg::DivW;
  localparam int FW    = pvif_pkg::FreqW;

  // Configuration registers
  logic [HopW-1:0]  hop_size;
  logic [Log2W-1:0] log2n;
  logic [HopW-1:0]  hop_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_size <= HopW'(256);
      log2n    <= Log2W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        pvif_pkg::REG_HOP:   hop_size <= cfg_data[HopW-1:0];
        pvif_pkg::REG_LOG2N: log2n    <= cfg_data[Log2W-1:0];
      endcase
    end
  end

  assign hop_eff = (hop_size == '0) ? HopW'(1) : hop_size;

  // Global advance: output register empty or being emptied
  logic en;
  logic out_valid;
  assign en        = !out_valid || freq.ready;
  assign bin.ready = en;

  // Prep stage: fold into right half plane, scale by 64
  logic signed [pvif_pkg::SampleW:0] re_ext, im_ext, re_f, im_f;
  logic                              left;
  pvif_pkg::cordic_t                 prep_next;
  pvif_pkg::cordic_t                 cq [pvif_pkg::CordicSteps+1];

  assign re_ext = {bin.bin_real[pvif_pkg::SampleW-1], bin.bin_real};
  assign im_ext = {bin.bin_imag[pvif_pkg::SampleW-1], bin.bin_imag};
  assign left   = bin.bin_real[pvif_pkg::SampleW-1];
  assign re_f   = left ? -re_ext : re_ext;
  assign im_f   = left ? -im_ext : im_ext;

  always_comb begin
    prep_next.valid = bin.valid;
    prep_next.j     = bin.bin_index;
    prep_next.first = bin.first_frame;
    prep_next.zero  = (bin.bin_real == '0) && (bin.bin_imag == '0);
    prep_next.x     = {{3{re_f[pvif_pkg::SampleW]}}, re_f, 6'b0};
    prep_next.y     = {{3{im_f[pvif_pkg::SampleW]}}, im_f, 6'b0};
    prep_next.z     = left ? 32'h8000_0000 : 32'h0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cq[0].valid <= 1'b0;
    end else if (en) begin
      cq[0] <= prep_next;
    end
  end

  // CORDIC chain
  for (genvar i = 0; i < pvif_pkg::CordicSteps; i++) begin : g_cordic
    pvif_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .din   (cq[i]),
      .shift (5'(i)),
      .angle (pvif_pkg::ATAN_TAB[i]),
      .dout  (cq[i+1])
    );
  end

  // Phase store stage: round to 16 bits, swap with the stored phase
  logic [31:0]              z_rnd;
  logic [PW-1:0]            cur;
  logic [HopW+BinW-1:0]     hj;
  logic [PW-1:0]            phase_mem [pvif_pkg::MaxBins];
  logic                     m_valid;
  logic [BinW-1:0]          m_j;
  logic [PW-1:0]            m_cur;
  logic [PW-1:0]            m_prev;
  logic [HopW+BinW-1:0]     m_hj;

  assign z_rnd = cq[pvif_pkg::CordicSteps].z + 32'h0000_8000;
  assign cur   = cq[pvif_pkg::CordicSteps].zero ? '0 : z_rnd[31:32-PW];
  assign hj    = {{BinW{1'b0}}, hop_eff} * {{HopW{1'b0}}, cq[pvif_pkg::CordicSteps].j};

  always_ff @(posedge clk) begin
    if (en && cq[pvif_pkg::CordicSteps].valid) begin
      m_prev <= phase_mem[cq[pvif_pkg::CordicSteps].j];
      phase_mem[cq[pvif_pkg::CordicSteps].j] <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= cq[pvif_pkg::CordicSteps].valid && !cq[pvif_pkg::CordicSteps].first;
      m_j     <= cq[pvif_pkg::CordicSteps].j;
      m_cur   <= cur;
      m_hj    <= hj;
    end
  end

  // Deviation stage 1: d*N - hop*j*P, modulo M = P*N
  logic [PW-1:0] d;
  logic [31:0]   d_sh;
  logic [31:0]   mask;
  logic [31:0]   u;
  logic          f1_valid;
  logic [BinW-1:0] f1_j;
  logic [31:0]   f1_u;

  assign d    = m_cur - m_prev;
  assign d_sh = {16'b0, d} << log2n;
  assign mask = (32'd1 << (5'd16 + {1'b0, log2n})) - 32'd1;
  assign u    = (d_sh - {m_hj[15:0], 16'b0}) & mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= m_valid;
      f1_j     <= m_j;
      f1_u     <= u;
    end
  end

  // Deviation stage 2: centre to [-M/2, M/2), add half divisor, scale down
  logic [31:0]        half;
  logic               wrap;
  logic [32:0]        modm;
  logic signed [32:0] dev;
  logic signed [33:0] den;
  logic signed [33:0] num;
  logic signed [33:0] scaled;
  logic               neg;
  logic [DW-1:0]      mag;
  pvif_pkg::div_t     dq [pvif_pkg::DivSteps+1];
  pvif_pkg::div_t     div_next;

  assign half   = 32'd1 << (5'd15 + {1'b0, log2n});
  assign wrap   = |(f1_u & half);
  assign modm   = {1'b0, mask} + 33'd1;
  assign dev    = $signed({1'b0, f1_u}) - (wrap ? $signed(modm) : 33'sd0);
  assign den    = $signed({23'b0, hop_eff} << log2n);
  assign num    = $signed({dev, 1'b0}) + den;
  assign scaled = num >>> ({1'b0, log2n} + 5'd1);
  assign neg    = scaled[DW];
  assign mag    = neg ? ~scaled[DW-1:0] : scaled[DW-1:0];

  always_comb begin
    div_next.valid = f1_valid;
    div_next.j     = f1_j;
    div_next.neg   = neg;
    div_next.rem   = '0;
    div_next.n     = mag;
    div_next.q     = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dq[0].valid <= 1'b0;
    end else if (en) begin
      dq[0] <= div_next;
    end
  end

  // Divider chain: rounded deviation divided by hop
  for (genvar k = 0; k < pvif_pkg::DivSteps; k++) begin : g_div
    pvif_div_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .hop  (hop_eff),
      .din  (dq[k]),
      .dout (dq[k+1])
    );
  end

  // Output register: bin centre plus deviation
  logic [BinW+15:0]   centre;
  logic [FW-1:0]      qsig;
  logic [FW-1:0]      freq_next;
  logic [FW-1:0]      out_freq;
  logic [BinW-1:0]    out_bin;

  assign centre    = {16'b0, dq[pvif_pkg::DivSteps].j} << (5'd16 - {1'b0, log2n});
  assign qsig      = dq[pvif_pkg::DivSteps].neg ? ~{2'b0, dq[pvif_pkg::DivSteps].q}
                                                :  {2'b0, dq[pvif_pkg::DivSteps].q};
  assign freq_next = centre[FW-1:0] + qsig;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dq[pvif_pkg::DivSteps].valid;
      out_freq  <= freq_next;
      out_bin   <= dq[pvif_pkg::DivSteps].j;
    end
  end

  assign freq.valid         = out_valid;
  assign freq.freq_angle    = $signed(out_freq);
  assign freq.bin_index_out = out_bin;

endmodule

/* rtl/pvif_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvif_checker - port-level checks for the phase vocoder frequency core
// Output hold, reset behaviour, flow control and result accounting.
// ----------------------------------------------------------------------------
module pvif_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_first,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pvif_pkg::FreqW-1:0]    out_freq,
  input logic [pvif_pkg::BinW-1:0]     out_bin
);

  // Results owed: non-first transactions in, minus results out
  logic [6:0] pending;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && in_ready && !in_first;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 7'(in_take) - 7'(out_take);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_freq) && $stable(out_bin)))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown straight after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_take |-> (pending != 7'd0))
    else $error("result without a matching input transaction");

endmodule

bind phase_vocoder_inst_freq_core pvif_checker u_pvif_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (bin.valid),
  .in_ready  (bin.ready),
  .in_first  (bin.first_frame),
  .out_valid (freq.valid),
  .out_ready (freq.ready),
  .out_freq  (freq.freq_angle),
  .out_bin   (freq.bin_index_out)
);
